/* rtl/core/vpcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpcd_pkg
// Request kinds, port window regions, mode register numbers and status layout
// shared by the video port command decoder.
// ----------------------------------------------------------------------------
package vpcd_pkg;

    typedef enum logic [2:0] {
        REQ_NONE     = 3'd0,
        REQ_FIFO_WR  = 3'd1,
        REQ_PREFETCH = 3'd2,
        REQ_PSG_WR   = 3'd3,
        REQ_TEST_WR  = 3'd4
    } req_kind_t;

    // port_offset[4:2] selects the region of the 32-byte window
    localparam logic [2:0] RGN_DATA      = 3'd0;
    localparam logic [2:0] RGN_CTRL      = 3'd1;
    localparam logic [2:0] RGN_HV_LO     = 3'd2;
    localparam logic [2:0] RGN_HV_HI     = 3'd3;
    localparam logic [2:0] RGN_PSG_LO    = 3'd4;
    localparam logic [2:0] RGN_PSG_HI    = 3'd5;
    localparam logic [2:0] RGN_TEST_ADDR = 3'd6;
    localparam logic [2:0] RGN_TEST_DATA = 3'd7;

    localparam logic [4:0] REG_MODE1   = 5'h00;
    localparam logic [4:0] REG_MODE2   = 5'h01;
    localparam logic [4:0] REG_MODE3   = 5'h0b;
    localparam logic [4:0] REG_MODE4   = 5'h0c;
    localparam logic [4:0] REG_AUTOINC = 5'h0f;
    localparam logic [4:0] REG_DMA_SRC = 5'h17;

    // control word code that marks a register write
    localparam logic [1:0] CODE_REG_WRITE = 2'd2;
    localparam logic [1:0] DMA_KIND_FILL  = 2'd2;

    // status bits 10, 12 and 13 always read as one
    localparam logic [15:0] STATUS_FIXED = 16'h3400;

    localparam int unsigned CMD_LOW_BITS = 14;
    localparam int unsigned CMD_FULL_BITS = 17;

endpackage

/* rtl/core/video_port_command_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_port_command_decoder
// Decodes bus accesses to the 32-byte video port window: command latch,
// data port requests, status and counter reads, register write events.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the input is accepted.
// Throughput: one item per cycle while out_ready holds; the single result
//   register paces it; a new item is taken in the same cycle as the result is.
// Reset: rst_n clears the command latch, mode state, sticky flags and the
//   result valid flag at once; no clearing pass.
module video_port_command_decoder #(
    parameter int ADDR_BITS = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic                 lower_lane,
    input  logic [4:0]           port_offset,
    input  logic [15:0]          bus_word,
    input  logic [7:0]           h_count,
    input  logic [8:0]           v_count,
    input  logic [15:0]          prefetch_word,
    input  logic [7:0]           live_status,
    input  logic [1:0]           sprite_events,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          read_word,
    output logic [2:0]           req_kind,
    output logic [3:0]           req_target,
    output logic [ADDR_BITS-1:0] req_address,
    output logic [15:0]          req_word,
    output logic                 dma_kick,
    output logic                 dma_fill_wait,
    output logic                 irq_repoll,
    output logic                 reg_written,
    output logic [4:0]           reg_number,
    output logic [7:0]           reg_value
);

    localparam int unsigned FULL = vpcd_pkg::CMD_FULL_BITS;
    localparam int unsigned LOW  = vpcd_pkg::CMD_LOW_BITS;

    // state
    logic [ADDR_BITS-1:0] cmd_address_reg, cmd_address_next;
    logic [3:0]           cmd_target_reg, cmd_target_next;
    logic                 cmd_second_pending_reg, cmd_second_pending_next;
    logic                 dma_pending_reg, dma_pending_next;
    logic [7:0]           auto_increment_reg, auto_increment_next;
    logic                 counter_hold_on_reg, counter_hold_on_next;
    logic [15:0]          held_counter_reg, held_counter_next;
    logic [1:0]           interlace_sel_reg, interlace_sel_next;
    logic                 display_on_reg, display_on_next;
    logic                 dma_allowed_reg, dma_allowed_next;
    logic [1:0]           dma_kind_reg, dma_kind_next;
    logic                 sticky_collision_reg, sticky_collision_next;
    logic                 sticky_overflow_reg, sticky_overflow_next;
    logic [3:0]           test_select_reg, test_select_next;

    // result register
    logic                 out_valid_reg;
    logic [15:0]          read_word_reg, read_word_next;
    vpcd_pkg::req_kind_t  req_kind_reg, req_kind_next;
    logic [3:0]           req_target_reg, req_target_next;
    logic [ADDR_BITS-1:0] req_address_reg, req_address_next;
    logic [15:0]          req_word_reg, req_word_next;
    logic                 dma_kick_reg, dma_kick_next;
    logic                 dma_fill_wait_reg, dma_fill_wait_next;
    logic                 irq_repoll_reg, irq_repoll_next;
    logic                 reg_written_reg, reg_written_next;
    logic [4:0]           reg_number_reg, reg_number_next;
    logic [7:0]           reg_value_reg, reg_value_next;

    logic                 accept;
    logic [ADDR_BITS-1:0] addr_stepped;
    logic [FULL-1:0]      addr_hi_load;
    logic [FULL-1:0]      addr_lo_load;
    logic [8:0]           vc_shift;
    logic [8:0]           vc_fold;
    logic [15:0]          live_counter;
    logic                 coll_seen;
    logic                 ovfl_seen;
    logic                 dma_pend_base;
    logic [15:0]          status_word;
    logic [1:0]           ctrl_code;
    logic [3:0]           target_hi;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign addr_stepped = cmd_address_reg + ADDR_BITS'(auto_increment_reg);

    // second command word replaces address bits 16:14
    assign addr_hi_load = (FULL'(cmd_address_reg) & FULL'(17'h03fff))
                        | (FULL'(bus_word[2:0]) << LOW);
    // first command word replaces address bits 13:0
    assign addr_lo_load = (FULL'(cmd_address_reg) & ~FULL'(17'h03fff))
                        | FULL'(bus_word[LOW-1:0]);

    // interlace folding of the vertical counter
    assign vc_shift = interlace_sel_reg[1] ? {v_count[7:0], 1'b0} : v_count;
    assign vc_fold  = interlace_sel_reg[0] ? {vc_shift[8:1], vc_shift[8]} : v_count;
    assign live_counter = {vc_fold[7:0], h_count};

    assign coll_seen     = sticky_collision_reg || sprite_events[0];
    assign ovfl_seen     = sticky_overflow_reg || sprite_events[1];
    assign dma_pend_base = dma_pending_reg && !live_status[7];

    assign status_word = vpcd_pkg::STATUS_FIXED
                       | {6'd0, live_status[6], live_status[5], live_status[4],
                          ovfl_seen, coll_seen,
                          interlace_sel_reg[0] & live_status[3],
                          live_status[2] | ~display_on_reg,
                          live_status[1], dma_pend_base, live_status[0]};

    assign ctrl_code = bus_word[15:14];
    assign target_hi = {bus_word[5:4], cmd_target_reg[1:0]};

    always_comb
    begin
        cmd_address_next        = cmd_address_reg;
        cmd_target_next         = cmd_target_reg;
        cmd_second_pending_next = cmd_second_pending_reg;
        dma_pending_next        = dma_pend_base;
        auto_increment_next     = auto_increment_reg;
        counter_hold_on_next    = counter_hold_on_reg;
        held_counter_next       = held_counter_reg;
        interlace_sel_next      = interlace_sel_reg;
        display_on_next         = display_on_reg;
        dma_allowed_next        = dma_allowed_reg;
        dma_kind_next           = dma_kind_reg;
        sticky_collision_next   = coll_seen;
        sticky_overflow_next    = ovfl_seen;
        test_select_next        = test_select_reg;

        read_word_next     = 16'd0;
        req_kind_next      = vpcd_pkg::REQ_NONE;
        req_target_next    = 4'd0;
        req_address_next   = '0;
        req_word_next      = 16'd0;
        dma_kick_next      = 1'b0;
        dma_fill_wait_next = 1'b0;
        irq_repoll_next    = 1'b0;
        reg_written_next   = 1'b0;
        reg_number_next    = 5'd0;
        reg_value_next     = 8'd0;

        if (!func) begin
            read_word_next = bus_word;      // open bus unless mapped
            unique case (port_offset[4:2])
                vpcd_pkg::RGN_DATA:
                begin
                    cmd_second_pending_next = 1'b0;
                    cmd_address_next        = addr_stepped;
                    req_kind_next           = vpcd_pkg::REQ_PREFETCH;
                    req_target_next         = cmd_target_reg;
                    req_address_next        = addr_stepped;
                    read_word_next          = prefetch_word;
                end
                vpcd_pkg::RGN_CTRL:
                begin
                    cmd_second_pending_next = 1'b0;
                    read_word_next          = status_word;
                    sticky_collision_next   = 1'b0;
                    sticky_overflow_next    = 1'b0;
                end
                vpcd_pkg::RGN_HV_LO, vpcd_pkg::RGN_HV_HI:
                begin
                    read_word_next = counter_hold_on_reg ? held_counter_reg : live_counter;
                end
                vpcd_pkg::RGN_PSG_LO, vpcd_pkg::RGN_PSG_HI,
                vpcd_pkg::RGN_TEST_ADDR, vpcd_pkg::RGN_TEST_DATA:
                begin
                    read_word_next = bus_word;
                end
            endcase
        end else begin
            unique case (port_offset[4:2])
                vpcd_pkg::RGN_DATA:
                begin
                    cmd_second_pending_next = 1'b0;
                    req_kind_next           = vpcd_pkg::REQ_FIFO_WR;
                    req_target_next         = cmd_target_reg;
                    req_address_next        = cmd_address_reg;
                    req_word_next           = bus_word;
                    cmd_address_next        = addr_stepped;
                end
                vpcd_pkg::RGN_CTRL:
                begin
                    if (cmd_second_pending_reg) begin
                        cmd_second_pending_next = 1'b0;
                        cmd_address_next        = addr_hi_load[ADDR_BITS-1:0];
                        cmd_target_next         = target_hi;
                        dma_pending_next        = dma_pend_base
                                                | (bus_word[7] & dma_allowed_reg);
                        req_kind_next           = vpcd_pkg::REQ_PREFETCH;
                        req_target_next         = target_hi;
                        req_address_next        = addr_hi_load[ADDR_BITS-1:0];
                        dma_kick_next           = 1'b1;
                        dma_fill_wait_next      = (dma_kind_reg == vpcd_pkg::DMA_KIND_FILL);
                    end else begin
                        cmd_target_next = {cmd_target_reg[3:2], ctrl_code};
                        if (ctrl_code != vpcd_pkg::CODE_REG_WRITE) begin
                            cmd_address_next        = addr_lo_load[ADDR_BITS-1:0];
                            cmd_second_pending_next = 1'b1;
                        end else begin
                            reg_written_next = 1'b1;
                            reg_number_next  = bus_word[12:8];
                            reg_value_next   = bus_word[7:0];
                            unique case (bus_word[12:8])
                                vpcd_pkg::REG_MODE1:
                                begin
                                    // latch counters on the rising edge of hold
                                    if (!counter_hold_on_reg && bus_word[1]) begin
                                        held_counter_next = live_counter;
                                    end
                                    counter_hold_on_next = bus_word[1];
                                    irq_repoll_next      = 1'b1;
                                end
                                vpcd_pkg::REG_MODE2:
                                begin
                                    dma_allowed_next = bus_word[4];
                                    display_on_next  = bus_word[6];
                                    irq_repoll_next  = 1'b1;
                                end
                                vpcd_pkg::REG_MODE3:
                                begin
                                    irq_repoll_next = 1'b1;
                                end
                                vpcd_pkg::REG_MODE4:
                                begin
                                    interlace_sel_next = bus_word[2:1];
                                end
                                vpcd_pkg::REG_AUTOINC:
                                begin
                                    auto_increment_next = bus_word[7:0];
                                end
                                vpcd_pkg::REG_DMA_SRC:
                                begin
                                    dma_kind_next = bus_word[7:6];
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                vpcd_pkg::RGN_HV_LO, vpcd_pkg::RGN_HV_HI:
                begin
                    // counters are read-only
                end
                vpcd_pkg::RGN_PSG_LO, vpcd_pkg::RGN_PSG_HI:
                begin
                    if (lower_lane) begin
                        req_kind_next = vpcd_pkg::REQ_PSG_WR;
                        req_word_next = bus_word;
                    end
                end
                vpcd_pkg::RGN_TEST_ADDR:
                begin
                    test_select_next = bus_word[3:0];
                end
                vpcd_pkg::RGN_TEST_DATA:
                begin
                    req_kind_next = vpcd_pkg::REQ_TEST_WR;
                    req_word_next = bus_word;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_address_reg        <= '0;
            cmd_target_reg         <= 4'd0;
            cmd_second_pending_reg <= 1'b0;
            dma_pending_reg        <= 1'b0;
            auto_increment_reg     <= 8'd0;
            counter_hold_on_reg    <= 1'b0;
            held_counter_reg       <= 16'd0;
            interlace_sel_reg      <= 2'd0;
            display_on_reg         <= 1'b0;
            dma_allowed_reg        <= 1'b0;
            dma_kind_reg           <= 2'd0;
            sticky_collision_reg   <= 1'b0;
            sticky_overflow_reg    <= 1'b0;
            test_select_reg        <= 4'd0;
            out_valid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                cmd_address_reg        <= cmd_address_next;
                cmd_target_reg         <= cmd_target_next;
                cmd_second_pending_reg <= cmd_second_pending_next;
                dma_pending_reg        <= dma_pending_next;
                auto_increment_reg     <= auto_increment_next;
                counter_hold_on_reg    <= counter_hold_on_next;
                held_counter_reg       <= held_counter_next;
                interlace_sel_reg      <= interlace_sel_next;
                display_on_reg         <= display_on_next;
                dma_allowed_reg        <= dma_allowed_next;
                dma_kind_reg           <= dma_kind_next;
                sticky_collision_reg   <= sticky_collision_next;
                sticky_overflow_reg    <= sticky_overflow_next;
                test_select_reg        <= test_select_next;
                out_valid_reg          <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept) begin
            read_word_reg     <= read_word_next;
            req_kind_reg      <= req_kind_next;
            req_target_reg    <= req_target_next;
            req_address_reg   <= req_address_next;
            req_word_reg      <= req_word_next;
            dma_kick_reg      <= dma_kick_next;
            dma_fill_wait_reg <= dma_fill_wait_next;
            irq_repoll_reg    <= irq_repoll_next;
            reg_written_reg   <= reg_written_next;
            reg_number_reg    <= reg_number_next;
            reg_value_reg     <= reg_value_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_word     = read_word_reg;
    assign req_kind      = 3'(req_kind_reg);
    assign req_target    = req_target_reg;
    assign req_address   = req_address_reg;
    assign req_word      = req_word_reg;
    assign dma_kick      = dma_kick_reg;
    assign dma_fill_wait = dma_fill_wait_reg;
    assign irq_repoll    = irq_repoll_reg;
    assign reg_written   = reg_written_reg;
    assign reg_number    = reg_number_reg;
    assign reg_value     = reg_value_reg;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the video port command decoder. Drives bus accesses
// over a valid/ready channel: a directed opener, then about 400 random items
// built mostly from command sequences, register writes, status and counter
// reads. Every result is checked field by field against a predictor.
// ----------------------------------------------------------------------------
package vpcd_tb_pkg;
    import vpcd_pkg::*;

    localparam int ADDR_W = 17;

    typedef struct {
        bit        func;
        bit        lower;
        bit [4:0]  off;
        bit [15:0] word;
        bit [7:0]  h;
        bit [8:0]  v;
        bit [15:0] pref;
        bit [7:0]  ls;
        bit [1:0]  ev;
    } access_t;

    typedef struct {
        logic [15:0]       read_word;
        req_kind_t         kind;
        logic [3:0]        target;
        logic [ADDR_W-1:0] address;
        logic [15:0]       word;
        logic              kick;
        logic              fill;
        logic              irq;
        logic              regw;
        logic [4:0]        regn;
        logic [7:0]        regv;
    } outcome_t;

    class decode_scoreboard;
        bit [ADDR_W-1:0] cmd_addr;
        bit [3:0]        target;
        bit              second_pending;
        bit              dma_pend;
        bit [7:0]        autoinc;
        bit              hold_on;
        bit [15:0]       held;
        bit [1:0]        ilace;
        bit              disp_on;
        bit              dma_en;
        bit [1:0]        dma_mode;
        bit              coll;
        bit              ovf;
        bit [3:0]        test_sel;
        outcome_t        expected_outcomes[$];
        int              failures;

        // H/V word with interlace folding of the line counter
        function bit [15:0] counter_word(bit [7:0] h, bit [8:0] v);
            bit [8:0] vc;
            vc = v;
            if (ilace[0])
            begin
                if (ilace[1])
                    vc = {vc[7:0], 1'b0};
                vc = {vc[8:1], vc[8]};
            end
            return {vc[7:0], h};
        endfunction

        function outcome_t decode_access(access_t a);
            outcome_t o;
            bit [4:0] num;
            bit [7:0] val;
            o.read_word = '0;
            o.kind      = REQ_NONE;
            o.target    = '0;
            o.address   = '0;
            o.word      = '0;
            o.kick      = 1'b0;
            o.fill      = 1'b0;
            o.irq       = 1'b0;
            o.regw      = 1'b0;
            o.regn      = '0;
            o.regv      = '0;

            if (a.ev[0])
                coll = 1'b1;
            if (a.ev[1])
                ovf = 1'b1;
            if (a.ls[7])
                dma_pend = 1'b0;

            if (!a.func)
            begin
                o.read_word = a.word;
                case (a.off[4:2])
                    RGN_DATA:
                    begin
                        second_pending = 1'b0;
                        cmd_addr = cmd_addr + ADDR_W'(autoinc);
                        o.kind = REQ_PREFETCH;
                        o.target = target;
                        o.address = cmd_addr;
                        o.read_word = a.pref;
                    end
                    RGN_CTRL:
                    begin
                        second_pending = 1'b0;
                        o.read_word = STATUS_FIXED | {6'b0, a.ls[6], a.ls[5], a.ls[4], ovf, coll,
                                                      ilace[0] & a.ls[3], a.ls[2] | ~disp_on,
                                                      a.ls[1], dma_pend, a.ls[0]};
                        coll = 1'b0;
                        ovf = 1'b0;
                    end
                    RGN_HV_LO, RGN_HV_HI:
                        o.read_word = hold_on ? held : counter_word(a.h, a.v);
                    default: ;
                endcase
            end
            else
            begin
                case (a.off[4:2])
                    RGN_DATA:
                    begin
                        second_pending = 1'b0;
                        o.kind = REQ_FIFO_WR;
                        o.target = target;
                        o.address = cmd_addr;
                        o.word = a.word;
                        cmd_addr = cmd_addr + ADDR_W'(autoinc);
                    end
                    RGN_CTRL:
                    begin
                        if (second_pending)
                        begin
                            second_pending = 1'b0;
                            cmd_addr = {a.word[2:0], cmd_addr[CMD_LOW_BITS-1:0]};
                            target = {a.word[5:4], target[1:0]};
                            dma_pend = dma_pend | (a.word[7] & dma_en);
                            o.kind = REQ_PREFETCH;
                            o.target = target;
                            o.address = cmd_addr;
                            o.kick = 1'b1;
                            o.fill = (dma_mode == DMA_KIND_FILL);
                        end
                        else
                        begin
                            target = {target[3:2], a.word[15:14]};
                            if (a.word[15:14] != CODE_REG_WRITE)
                            begin
                                cmd_addr = {cmd_addr[ADDR_W-1:CMD_LOW_BITS],
                                            a.word[CMD_LOW_BITS-1:0]};
                                second_pending = 1'b1;
                            end
                            else
                            begin
                                num = a.word[12:8];
                                val = a.word[7:0];
                                o.regw = 1'b1;
                                o.regn = num;
                                o.regv = val;
                                case (num)
                                    REG_MODE1:
                                    begin
                                        if (!hold_on && val[1])
                                            held = counter_word(a.h, a.v);
                                        hold_on = val[1];
                                        o.irq = 1'b1;
                                    end
                                    REG_MODE2:
                                    begin
                                        dma_en = val[4];
                                        disp_on = val[6];
                                        o.irq = 1'b1;
                                    end
                                    REG_MODE3:   o.irq = 1'b1;
                                    REG_MODE4:   ilace = val[2:1];
                                    REG_AUTOINC: autoinc = val;
                                    REG_DMA_SRC: dma_mode = val[7:6];
                                    default: ;
                                endcase
                            end
                        end
                    end
                    RGN_PSG_LO, RGN_PSG_HI:
                    begin
                        if (a.lower)
                        begin
                            o.kind = REQ_PSG_WR;
                            o.word = a.word;
                        end
                    end
                    RGN_TEST_ADDR:
                        test_sel = a.word[3:0];
                    RGN_TEST_DATA:
                    begin
                        o.kind = REQ_TEST_WR;
                        o.word = a.word;
                    end
                    default: ;  // counters ignore writes
                endcase
            end
            return o;
        endfunction

        function void note_access(access_t a);
            expected_outcomes.push_back(decode_access(a));
        endfunction

        function int pending_count();
            return expected_outcomes.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no access waiting");
                failures++;
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("read_word", want.read_word, got.read_word);
            compare_field("req_kind", want.kind, got.kind);
            compare_field("req_target", want.target, got.target);
            compare_field("req_address", want.address, got.address);
            compare_field("req_word", want.word, got.word);
            compare_field("dma_kick", want.kick, got.kick);
            compare_field("dma_fill_wait", want.fill, got.fill);
            compare_field("irq_repoll", want.irq, got.irq);
            compare_field("reg_written", want.regw, got.regw);
            compare_field("reg_number", want.regn, got.regn);
            compare_field("reg_value", want.regv, got.regv);
        endfunction
    endclass
endpackage

module tb_top;
    import vpcd_pkg::*;
    import vpcd_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              func;
    logic              lower_lane;
    logic [4:0]        port_offset;
    logic [15:0]       bus_word;
    logic [7:0]        h_count;
    logic [8:0]        v_count;
    logic [15:0]       prefetch_word;
    logic [7:0]        live_status;
    logic [1:0]        sprite_events;
    logic              out_valid;
    logic              out_ready;
    logic [15:0]       read_word;
    logic [2:0]        req_kind;
    logic [3:0]        req_target;
    logic [ADDR_W-1:0] req_address;
    logic [15:0]       req_word;
    logic              dma_kick;
    logic              dma_fill_wait;
    logic              irq_repoll;
    logic              reg_written;
    logic [4:0]        reg_number;
    logic [7:0]        reg_value;

    decode_scoreboard sb;
    bit quiet;       // directed part: no stray sprite events or dma-finished
    bit no_gaps;
    int items_sent;
    int idle_cycles;

    video_port_command_decoder #(
        .ADDR_BITS(ADDR_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .lower_lane    (lower_lane),
        .port_offset   (port_offset),
        .bus_word      (bus_word),
        .h_count       (h_count),
        .v_count       (v_count),
        .prefetch_word (prefetch_word),
        .live_status   (live_status),
        .sprite_events (sprite_events),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_word     (read_word),
        .req_kind      (req_kind),
        .req_target    (req_target),
        .req_address   (req_address),
        .req_word      (req_word),
        .dma_kick      (dma_kick),
        .dma_fill_wait (dma_fill_wait),
        .irq_repoll    (irq_repoll),
        .reg_written   (reg_written),
        .reg_number    (reg_number),
        .reg_value     (reg_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic access_t region_access(bit wr, logic [2:0] rgn, bit [15:0] w);
        access_t a;
        a.func  = wr;
        a.lower = 1'($urandom);
        a.off   = {rgn, 2'($urandom_range(0, 3))};
        a.word  = w;
        a.h     = 8'($urandom);
        a.v     = 9'($urandom);
        a.pref  = 16'($urandom);
        a.ls    = 8'($urandom);
        a.ev    = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00;
        if (quiet)
        begin
            a.ls[7] = 1'b0;
            a.ev = 2'b00;
        end
        else
            a.ls[7] = ($urandom_range(0, 9) < 3);
        return a;
    endfunction

    task automatic send_access(access_t a);
        func          <= a.func;
        lower_lane    <= a.lower;
        port_offset   <= a.off;
        bus_word      <= a.word;
        h_count       <= a.h;
        v_count       <= a.v;
        prefetch_word <= a.pref;
        live_status   <= a.ls;
        sprite_events <= a.ev;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(a);
        items_sent++;
        // idle gaps after about 7% of items: roughly 16% idle
        if (!no_gaps && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_reg(bit [4:0] num, bit [7:0] val);
        send_access(region_access(1'b1, RGN_CTRL, {CODE_REG_WRITE, 1'($urandom), num, val}));
    endtask

    // two-word command; code must not be the register-write code
    task automatic send_command(bit [1:0] code, bit [16:0] addr, bit [1:0] hi, bit dma);
        send_access(region_access(1'b1, RGN_CTRL, {code, addr[13:0]}));
        send_access(region_access(1'b1, RGN_CTRL, {8'($urandom), dma, 1'($urandom), hi,
                                                   1'($urandom), addr[16:14]}));
    endtask

    // result side: random stalls, one long hold-off, one calm window
    initial
    begin
        int cyc;
        cyc = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 300)
            begin
                out_ready <= 1'b0;
                repeat (100) @(posedge clk);
                cyc += 100;
            end
            else if (cyc >= 450 && cyc < 600)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.read_word = read_word;
            got.kind      = req_kind_t'(req_kind);
            got.target    = req_target;
            got.address   = req_address;
            got.word      = req_word;
            got.kick      = dma_kick;
            got.fill      = dma_fill_wait;
            got.irq       = irq_repoll;
            got.regw      = reg_written;
            got.regn      = reg_number;
            got.regv      = reg_value;
            sb.check_outcome(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        access_t   a;
        bit [1:0]  code;
        bit [4:0]  num;
        bit [7:0]  val;
        int        pick;

        sb = new();
        idle_cycles = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        quiet = 1'b1;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= 1'b0;
        lower_lane    <= 1'b0;
        port_offset   <= '0;
        bus_word      <= '0;
        h_count       <= '0;
        v_count       <= '0;
        prefetch_word <= '0;
        live_status   <= '0;
        sprite_events <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opener
        send_access(region_access(1'b0, RGN_CTRL, 16'hffff));   // status, display off
        write_reg(REG_MODE2, 8'h50);                            // display on, dma allowed
        write_reg(REG_AUTOINC, 8'hff);
        send_command(2'd1, 17'h1ffff, 2'b11, 1'b1);             // sets dma pending
        send_access(region_access(1'b0, RGN_CTRL, 16'h0000));
        send_access(region_access(1'b1, RGN_DATA, 16'hffff));   // address wraps
        write_reg(REG_DMA_SRC, 8'h80);                          // fill mode
        send_command(2'd3, 17'h00000, 2'b00, 1'b0);
        a = region_access(1'b0, RGN_DATA, 16'h0000);
        a.ls[7] = 1'b1;                                         // dma finished
        send_access(a);
        send_access(region_access(1'b0, RGN_CTRL, 16'h0000));
        a = region_access(1'b0, RGN_CTRL, 16'h0000);
        a.ev = 2'b11;                                           // reported, then cleared
        send_access(a);
        send_access(region_access(1'b0, RGN_CTRL, 16'h0000));
        write_reg(REG_MODE4, 8'h06);
        a = region_access(1'b0, RGN_HV_LO, 16'h0000);
        a.v = 9'h1ff;
        send_access(a);
        write_reg(REG_MODE4, 8'h02);
        a = region_access(1'b0, RGN_HV_HI, 16'h0000);
        a.v = 9'h17f;
        a.h = 8'hff;
        send_access(a);
        write_reg(REG_MODE1, 8'h02);                            // latch counter
        send_access(region_access(1'b0, RGN_HV_LO, 16'h0000));
        write_reg(REG_MODE1, 8'h00);
        send_access(region_access(1'b1, RGN_HV_HI, 16'hffff)); // counter write ignored
        a = region_access(1'b1, RGN_PSG_LO, 16'h1234);
        a.lower = 1'b0;
        send_access(a);
        a.lower = 1'b1;
        send_access(a);
        send_access(region_access(1'b1, RGN_TEST_ADDR, 16'hffff));
        send_access(region_access(1'b0, RGN_TEST_ADDR, 16'h5a5a));
        send_access(region_access(1'b1, RGN_TEST_DATA, 16'hffff));
        send_access(region_access(1'b0, RGN_TEST_DATA, 16'ha5a5));
        write_reg(5'h1f, 8'hff);                                // unknown register
        write_reg(REG_AUTOINC, 8'h00);

        // random part: mostly well-formed sequences
        quiet = 1'b0;
        while (items_sent < 30 + RANDOM_ITEMS)
        begin
            no_gaps = (items_sent >= 180 && items_sent < 280);
            pick = $urandom_range(0, 99);
            code = 2'($urandom_range(0, 2));
            if (code == CODE_REG_WRITE)
                code = 2'd3;
            if (pick < 25)
            begin
                send_command(code, 17'($urandom), 2'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 6))
                    send_access(region_access(1'($urandom), RGN_DATA, 16'($urandom)));
            end
            else if (pick < 45)
            begin
                case ($urandom_range(0, 6))
                    0: num = REG_MODE1;
                    1: num = REG_MODE2;
                    2: num = REG_MODE3;
                    3: num = REG_MODE4;
                    4: num = REG_AUTOINC;
                    5: num = REG_DMA_SRC;
                    default: num = 5'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1: val = 8'h00;
                    2: val = 8'hff;
                    default: val = 8'($urandom);
                endcase
                write_reg(num, val);
            end
            else if (pick < 57)
                send_access(region_access(1'b0, RGN_CTRL, 16'($urandom)));
            else if (pick < 67)
                send_access(region_access(1'b0, 3'($urandom_range(RGN_HV_LO, RGN_HV_HI)),
                                          16'($urandom)));
            else if (pick < 77)
                send_access(region_access(1'($urandom),
                                          3'($urandom_range(RGN_PSG_LO, RGN_TEST_DATA)),
                                          16'($urandom)));
            else if (pick < 87)
            begin
                // first command word cut short by another access
                send_access(region_access(1'b1, RGN_CTRL, {code, 14'($urandom)}));
                send_access(region_access(1'($urandom), 3'($urandom), 16'($urandom)));
            end
            else
                send_access(region_access(1'($urandom), 3'($urandom), 16'($urandom)));
        end
        in_valid <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* files.f */
rtl/core/vpcd_pkg.sv
rtl/core/video_port_command_decoder.sv
dv/tb_top.sv
